FILE: src/lpfc_pkg.sv
// lpfc_pkg: shared constants and types for the lru page fault counter
// no dependencies; used by lpfc_cell and lru_page_fault_counter
package lpfc_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = 32;
  localparam int CAP_W      = 5;
  localparam int FCNT_W     = 32;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int OUT_W      = ((1 + FCNT_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

  // broadcast control from the top level to every stack cell
  typedef struct packed {
    logic [PAGE_W-1:0] page;     // page being looked up
    logic              hit;      // some cell matched
    logic              room;     // a free frame may be filled
    logic              advance;  // word accepted this cycle
    logic              clear;    // end of run, drop all frames
  } ctl_t;

endpackage

FILE: src/lpfc_cell.sv
// lpfc_cell: one entry of the lru stack, position in chain is recency rank
// depends on lpfc_pkg (ctl_t, PAGE_W)
module lpfc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  lpfc_pkg::ctl_t               ctl,
  input  logic [lpfc_pkg::PAGE_W-1:0]  prev_page,
  input  logic                         prev_valid,
  input  logic                         next_valid,
  input  logic                         stop_in,
  output logic [lpfc_pkg::PAGE_W-1:0]  page,
  output logic                         valid,
  output logic                         match,
  output logic                         stop_out
);

  logic last_valid;
  logic term;
  logic shift;

  assign match      = valid && (page == ctl.page);
  assign last_valid = valid && !next_valid;
  // shift stops at the hit, at the first free entry, or at the lru entry
  assign term       = match ||
                      (!ctl.hit && ((!valid && ctl.room) || (last_valid && !ctl.room)));
  assign shift      = !stop_in;
  assign stop_out   = stop_in || term;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.advance && ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.advance && shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && shift) begin
      page <= prev_page;
    end
  end

endmodule

FILE: src/lru_page_fault_counter.sv
// lru_page_fault_counter: lru page replacement with a running fault count
// latency: each accepted input word yields its registered output word in the next cycle
// throughput: one word per cycle while the receiver takes output words; lookup and stack shift happen in the same cycle
// reset (rst, synchronous): all frames invalid, counts zero, capacity 4
// end of run (tlast): result carries the total, then frames and count clear
// depends on lpfc_pkg and lpfc_cell
module lru_page_fault_counter (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: capacity register
  input  logic                          cfg_we,
  input  logic [lpfc_pkg::CAP_W-1:0]    cfg_wdata,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lpfc_pkg::PAGE_W-1:0]   s_axis_tdata,   // [31:0] page_number
  input  logic                          s_axis_tlast,   // end_of_sequence
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lpfc_pkg::OUT_W-1:0]    m_axis_tdata,   // [0] fault, [32:1] fault_count
  output logic                          m_axis_tlast    // run_done
);

  localparam int MAXF = lpfc_pkg::MAX_FRAMES;

  // configuration register, kept across runs
  logic [lpfc_pkg::CAP_W-1:0]  capacity;
  // run state
  logic [lpfc_pkg::CNT_W-1:0]  resident_count;
  logic [lpfc_pkg::FCNT_W-1:0] faults_so_far;
  // output word register
  logic                        out_fault;
  logic [lpfc_pkg::FCNT_W-1:0] out_count;

  logic                        acc;
  lpfc_pkg::ctl_t              ctl;
  logic [lpfc_pkg::CMP_W-1:0]  cap_ext;
  logic [lpfc_pkg::CMP_W-1:0]  cap_eff;
  logic [lpfc_pkg::CMP_W-1:0]  count_ext;
  logic                        hit;
  logic                        room;
  logic [lpfc_pkg::FCNT_W-1:0] faults_next;

  // stack of cells: cell 0 is most recent, valid entries form a prefix
  logic [lpfc_pkg::PAGE_W-1:0] cell_page [MAXF];
  logic [MAXF-1:0]             cell_valid;
  logic [MAXF-1:0]             match_v;
  logic [MAXF:0]               stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lpfc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // output register frees the input side whenever the word can move on
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // capacity zero acts as one, above the built depth clamps to it
  assign cap_ext   = lpfc_pkg::CMP_W'(capacity);
  assign count_ext = lpfc_pkg::CMP_W'(resident_count);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = lpfc_pkg::CMP_W'(1);
    end else if (cap_ext > lpfc_pkg::CMP_W'(MAXF)) begin
      cap_eff = lpfc_pkg::CMP_W'(MAXF);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign hit  = |match_v;
  assign room = count_ext < cap_eff;

  assign ctl.page    = s_axis_tdata;
  assign ctl.hit     = hit;
  assign ctl.room    = room;
  assign ctl.advance = acc;
  assign ctl.clear   = s_axis_tlast;

  // shift chain: cells up to the stopping cell take their neighbor's entry,
  // cell 0 takes the new page, so a miss when full drops the lru entry
  assign stop[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAXF; gi++) begin : g_cell
      logic [lpfc_pkg::PAGE_W-1:0] pp;
      logic                        pv;
      logic                        nv;
      if (gi == 0) begin : g_head
        assign pp = s_axis_tdata;
        assign pv = 1'b1;
      end else begin : g_body
        assign pp = cell_page[gi-1];
        assign pv = cell_valid[gi-1];
      end
      if (gi == MAXF - 1) begin : g_tail
        assign nv = 1'b0;
      end else begin : g_mid
        assign nv = cell_valid[gi+1];
      end
      lpfc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_page  (pp),
        .prev_valid (pv),
        .next_valid (nv),
        .stop_in    (stop[gi]),
        .page       (cell_page[gi]),
        .valid      (cell_valid[gi]),
        .match      (match_v[gi]),
        .stop_out   (stop[gi+1])
      );
    end
  endgenerate

  // saturating fault count including this reference
  always_comb begin
    faults_next = faults_so_far;
    if (!hit && (faults_so_far != '1)) begin
      faults_next = faults_so_far + lpfc_pkg::FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident_count <= '0;
      faults_so_far  <= '0;
    end else if (acc) begin
      if (s_axis_tlast) begin
        resident_count <= '0;
        faults_so_far  <= '0;
      end else begin
        faults_so_far <= faults_next;
        if (!hit && room) begin
          resident_count <= resident_count + lpfc_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_fault    <= !hit;
      out_count    <= faults_next;
      m_axis_tlast <= s_axis_tlast;
    end
  end

  assign m_axis_tdata = lpfc_pkg::OUT_W'({out_count, out_fault});

`ifndef ASSERT_OFF
  // occupied entries always match the residency counter
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(resident_count))
    else $error("residency count disagrees with valid cells");

  // a page is never resident in two cells
  a_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_v))
    else $error("page resident in more than one cell");

  // end of run empties the stack and zeroes the count
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tlast) |=> (resident_count == '0 && faults_so_far == '0))
    else $error("run state not cleared after end of run");

  // a hit leaves residency unchanged
  a_hit_keep: assert property (@(posedge clk) disable iff (rst)
    (acc && !s_axis_tlast && hit) |=> resident_count == $past(resident_count))
    else $error("residency changed on a hit");
`endif

endmodule

FILE: verif/lru_page_fault_counter_tb.sv
// lru_page_fault_counter_tb: self-checking bench for the lru page fault counter
// drives page references on the input stream and checks fault flag, count and run end
// depends on lpfc_pkg and lru_page_fault_counter
`timescale 1ns / 100ps

module lru_page_fault_counter_tb;
  import lpfc_pkg::*;

  typedef struct {
    logic              fault;
    logic [FCNT_W-1:0] count;
    logic              done;
  } fault_result_t;

  // lru frame model plus the queue of results still owed by the block
  class lru_scoreboard;
    logic [PAGE_W-1:0] frame_page[MAX_FRAMES];
    bit                frame_used[MAX_FRAMES];
    int unsigned       frame_age[MAX_FRAMES];
    int unsigned       resident;
    logic [FCNT_W-1:0] faults;
    logic [CAP_W-1:0]  capacity;
    fault_result_t     owed_q[$];
    int unsigned       errors;

    function new();
      clear_run();
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void clear_run();
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_page[i] = '0;
        frame_used[i] = 0;
        frame_age[i] = 0;
      end
      resident = 0;
      faults = '0;
    endfunction

    // frame k becomes most recent, occupied frames younger than limit age by one
    function void make_recent(int k, int unsigned limit);
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (frame_used[i] && i != k && frame_age[i] < limit) frame_age[i]++;
      end
      frame_age[k] = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_reference(logic [PAGE_W-1:0] page, logic last);
      int            hit_frame;
      int            slot;
      int unsigned   eff_cap;
      int unsigned   oldest;
      fault_result_t res;
      hit_frame = -1;
      slot = -1;
      oldest = 0;
      // zero acts as one frame, anything above the build depth saturates
      eff_cap = (capacity == 0) ? 1 : capacity;
      if (eff_cap > MAX_FRAMES) eff_cap = MAX_FRAMES;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (hit_frame < 0 && frame_used[i] && frame_page[i] == page) hit_frame = i;
      end
      res.fault = (hit_frame < 0);
      if (hit_frame >= 0) begin
        make_recent(hit_frame, frame_age[hit_frame]);
      end else begin
        if (faults != '1) faults++;
        if (resident < eff_cap) begin
          for (int i = 0; i < MAX_FRAMES; i++) begin
            if (slot < 0 && !frame_used[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          frame_used[slot] = 1;
          frame_page[slot] = page;
          make_recent(slot, MAX_FRAMES + 1);
          resident++;
        end else begin
          // evict the least recent frame, residency stays where it is
          for (int i = 0; i < MAX_FRAMES; i++) begin
            if (frame_used[i] && (slot < 0 || frame_age[i] > oldest)) begin
              oldest = frame_age[i];
              slot = i;
            end
          end
          if (slot >= 0) begin
            frame_page[slot] = page;
            make_recent(slot, oldest);
          end
        end
      end
      res.count = faults;
      res.done = last;
      owed_q.push_back(res);
      if (last) clear_run();
    endfunction

    function void check_result(logic fault, logic [FCNT_W-1:0] count, logic done);
      fault_result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected word fault=%0b count=%0d done=%0b",
                 $time, fault, count, done);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (fault !== exp_r.fault) begin
        $display("%0t: fault mismatch expected %0b actual %0b", $time, exp_r.fault, fault);
        errors++;
      end
      if (count !== exp_r.count) begin
        $display("%0t: fault_count mismatch expected %0d actual %0d",
                 $time, exp_r.count, count);
        errors++;
      end
      if (done !== exp_r.done) begin
        $display("%0t: run_done mismatch expected %0b actual %0b", $time, exp_r.done, done);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CAP_W-1:0]   cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [PAGE_W-1:0]  s_axis_tdata;   // [31:0] page_number
  logic               s_axis_tlast;   // end_of_sequence
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;   // [0] fault, [32:1] fault_count
  logic               m_axis_tlast;   // run_done

  lru_scoreboard      sb;
  int unsigned        src_idle_pct;
  int unsigned        sink_idle_pct;
  bit                 hold_request;
  logic [PAGE_W-1:0]  page_pool[32];
  int unsigned        pool_span;

  lru_page_fault_counter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random backpressure, plus one long hold-off counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[0], m_axis_tdata[FCNT_W:1], m_axis_tlast);
  end

  // called at a falling edge, returns at a falling edge after the word is taken
  task automatic send_word(input logic [PAGE_W-1:0] page, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= page;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_reference(page, last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  // half wide random pages, half small ids, so every data bit toggles
  task automatic refresh_pool();
    for (int i = 0; i < 32; i++)
      page_pool[i] = (i % 2) ? $urandom : $urandom_range(0, 40);
    pool_span = $urandom_range(1, 24);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
    int unsigned       pick;
    logic [PAGE_W-1:0] page;
    logic              last;
    wait_drained();
    write_capacity(cap);
    refresh_pool();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) page = page_pool[$urandom_range(0, pool_span)];
      else if (pick < 88) page = $urandom_range(0, 15);
      else page = $urandom;
      last = ($urandom_range(0, 39) == 0);
      send_word(page, last);
      if (last) refresh_pool();
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset capacity of four: fill, hit, two evictions, close the run
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0003, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0002, 1'b1);
    send_word(32'h0000_0002, 1'b0);

    // zero capacity behaves as a single frame
    wait_drained();
    write_capacity('0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_0005, 1'b0);
    send_word(32'h0000_0006, 1'b1);

    // all-ones capacity saturates to the build depth
    wait_drained();
    write_capacity('1);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);

    // capacity dropped below residency mid-run: faults replace, residency holds
    // the receiver holds off here while the sender keeps offering words
    wait_drained();
    write_capacity(CAP_W'(2));
    hold_request = 1;
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h0000_0007, 1'b0);
    send_word(32'h0000_0008, 1'b0);
    send_word(32'h1234_5678, 1'b1);

    // random part, runs carry over phase boundaries so capacity changes mid-run too
    src_idle_pct = 32;
    sink_idle_pct = 54;
    run_phase(CAP_W'(3), 90);
    run_phase(CAP_W'(16), 90);
    src_idle_pct = 54;
    sink_idle_pct = 32;
    run_phase(CAP_W'(1), 90);
    run_phase('1, 90);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_phase('0, 90);
    run_phase(CAP_W'($urandom_range(2, 15)), 90);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lpfc_pkg.sv
src/lpfc_cell.sv
src/lru_page_fault_counter.sv
verif/lru_page_fault_counter_tb.sv
